// File: hdl/dcp_pkg.sv
// Shared types and constants for the constant propagation block.
package dcp_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam logic [5:0] ITER_LAST = 6'd63;

	typedef enum logic [4:0] {
		K_CONST = 5'd0, K_ADD = 5'd1, K_SUB = 5'd2, K_MUL = 5'd3, K_DIV = 5'd4,
		K_MOD = 5'd5, K_AND = 5'd6, K_OR = 5'd7, K_XOR = 5'd8, K_SHL = 5'd9,
		K_SHR = 5'd10, K_SAR = 5'd11, K_EQ = 5'd12, K_NE = 5'd13, K_LT = 5'd14,
		K_GT = 5'd15, K_LE = 5'd16, K_GE = 5'd17, K_OTHER = 5'd18
	} kind_t;

	typedef enum logic [1:0] {
		LAT_UNKNOWN = 2'd0,
		LAT_CONST   = 2'd1,
		LAT_OVER    = 2'd2
	} lat_kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] val;
	} lat_t;

	typedef struct packed {
		logic [63:0] literal;
		logic [6:0]  right;
		logic [6:0]  left;
		logic [1:0]  opcnt;
		logic        already_const;
		logic        is_pure;
		logic        dead;
		logic [4:0]  kind;
	} node_t;

	typedef enum logic [3:0] {
		S_LOAD, S_RD_NODE, S_OPS, S_OWN, S_EVAL, S_ITER, S_WB, S_OUT_RD, S_OUT_CAP
	} state_t;

endpackage

// File: hdl/dcp_ram.sv
// Generic single-write, single-read memory with registered read data.
module dcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/dataflow_constant_propagation.sv
// Top level: constant propagation over a loaded expression table.
// Load: one node word per cycle. Sweep per node: node read, operand read; a live node
// adds own read, eval, write-back and, for a folded mul, div or mod, iterate on the
// shared bit-serial unit. Sweeps repeat until nothing changes, at most node count + 1
// times. Report: each word is read, then captured; input is held off until the last.
// Reset clears the control state and count; lattice valid bits clear at run start.
module dataflow_constant_propagation #(
	parameter int MAX_NODES = dcp_pkg::MAX_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// is_dead, is_pure, already_const, operand_count[1:0], left_operand[6:0],
	// right_operand[6:0], literal_value[63:0], zero pad
	input  logic [87:0] s_tdata,
	// node_kind[4:0]
	input  logic [4:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// node_index[6:0], folded_value[63:0], mark_const
	output logic [71:0] m_tdata,
	// lattice_kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int SW = $clog2(MAX_NODES + 2);
	localparam int NW = $bits(dcp_pkg::node_t);
	localparam int LW = $bits(dcp_pkg::lat_t);

	dcp_pkg::state_t state_q, state_d;

	logic [CW-1:0]        count_q;   // nodes stored
	logic [AW-1:0]        idx_q;     // node under work
	logic [SW-1:0]        sweep_q;   // sweeps finished
	logic                 changed_q; // this sweep changed a value
	logic [MAX_NODES-1:0] vld_q;     // lattice entry written this run

	dcp_pkg::node_t nd_q;
	dcp_pkg::lat_t  a_q, b_q, nv_q;
	logic           a_vld_q, b_vld_q, own_vld_q;

	// bit-serial arithmetic unit
	logic [63:0] acc_q, x_q, y_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_nx, x_nx, y_nx, trial;

	// memories
	logic           node_we, node_re, lat_we, lat_re_a, lat_re_b;
	logic [AW-1:0]  node_raddr, lat_raddr_a, lat_raddr_b;
	logic [NW-1:0]  node_rdata_w;
	logic [LW-1:0]  lat_rdata_a_w, lat_rdata_b_w;
	dcp_pkg::node_t node_wr, node_rd;
	dcp_pkg::lat_t  lat_a_rd, lat_b_rd, old_val;

	logic        s_acc, m_free, last_i, more_sweeps, chg;

	// output register
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;

	assign node_wr.kind          = s_tuser;
	assign node_wr.dead          = s_tdata[0];
	assign node_wr.is_pure       = s_tdata[1];
	assign node_wr.already_const = s_tdata[2];
	assign node_wr.opcnt         = s_tdata[4:3];
	assign node_wr.left          = s_tdata[11:5];
	assign node_wr.right         = s_tdata[18:12];
	assign node_wr.literal       = s_tdata[82:19];

	assign s_tready = (state_q == dcp_pkg::S_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign node_we  = s_acc && (count_q < CW'(MAX_NODES));
	assign node_rd  = dcp_pkg::node_t'(node_rdata_w);
	assign lat_a_rd = dcp_pkg::lat_t'(lat_rdata_a_w);
	assign lat_b_rd = dcp_pkg::lat_t'(lat_rdata_b_w);
	assign old_val  = own_vld_q ? lat_a_rd : '0;
	assign m_free   = !m_tvalid_q || m_tready;

	assign last_i      = (CW'(idx_q) + CW'(1)) == count_q;
	assign chg         = (state_q == dcp_pkg::S_WB) && (nv_q != old_val);
	assign more_sweeps = (changed_q || chg) && (sweep_q < SW'(count_q));

	dcp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(AW'(count_q)), .wdata(node_wr),
		.re(node_re), .raddr(node_raddr), .rdata(node_rdata_w)
	);

	// two copies of the lattice give both operands in the same cycle
	dcp_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_lat_a_ram (
		.clk(clk), .we(lat_we), .waddr(idx_q), .wdata(nv_q),
		.re(lat_re_a), .raddr(lat_raddr_a), .rdata(lat_rdata_a_w)
	);

	dcp_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_lat_b_ram (
		.clk(clk), .we(lat_we), .waddr(idx_q), .wdata(nv_q),
		.re(lat_re_b), .raddr(lat_raddr_b), .rdata(lat_rdata_b_w)
	);

	// quick fold for everything but mul, and div or mod by a nonzero divisor
	dcp_pkg::lat_t quick_nv;
	logic          need_iter;
	logic [5:0]    sh;
	logic          lt_ab, lt_ba;

	assign sh    = b_q.val[5:0];
	assign lt_ab = $signed(a_q.val) < $signed(b_q.val);
	assign lt_ba = $signed(b_q.val) < $signed(a_q.val);

	always_comb begin
		quick_nv  = '{kind: dcp_pkg::LAT_OVER, val: 64'd0};
		need_iter = 1'b0;
		if (nd_q.kind == dcp_pkg::K_CONST) begin
			quick_nv = '{kind: dcp_pkg::LAT_CONST, val: nd_q.literal};
		end else if (nd_q.kind > dcp_pkg::K_GE) begin
			quick_nv = '{kind: dcp_pkg::LAT_OVER, val: 64'd0};
		end else if (nd_q.opcnt != 2'd2) begin
			quick_nv = '{kind: dcp_pkg::LAT_OVER, val: 64'd0};
		end else if (a_q.kind == dcp_pkg::LAT_UNKNOWN || b_q.kind == dcp_pkg::LAT_UNKNOWN) begin
			quick_nv = '{kind: dcp_pkg::LAT_UNKNOWN, val: 64'd0};
		end else if (a_q.kind == dcp_pkg::LAT_OVER || b_q.kind == dcp_pkg::LAT_OVER) begin
			quick_nv = '{kind: dcp_pkg::LAT_OVER, val: 64'd0};
		end else begin
			quick_nv.kind = dcp_pkg::LAT_CONST;
			case (nd_q.kind) inside
				dcp_pkg::K_ADD: quick_nv.val = a_q.val + b_q.val;
				dcp_pkg::K_SUB: quick_nv.val = a_q.val - b_q.val;
				dcp_pkg::K_MUL: need_iter = 1'b1;
				dcp_pkg::K_DIV, dcp_pkg::K_MOD: begin
					if (b_q.val == 64'd0) quick_nv = '{kind: dcp_pkg::LAT_UNKNOWN, val: 64'd0};
					else need_iter = 1'b1;
				end
				dcp_pkg::K_AND: quick_nv.val = a_q.val & b_q.val;
				dcp_pkg::K_OR:  quick_nv.val = a_q.val | b_q.val;
				dcp_pkg::K_XOR: quick_nv.val = a_q.val ^ b_q.val;
				dcp_pkg::K_SHL: quick_nv.val = a_q.val << sh;
				dcp_pkg::K_SHR: quick_nv.val = a_q.val >> sh;
				dcp_pkg::K_SAR: quick_nv.val = 64'($signed(a_q.val) >>> sh);
				dcp_pkg::K_EQ:  quick_nv.val = {63'd0, a_q.val == b_q.val};
				dcp_pkg::K_NE:  quick_nv.val = {63'd0, a_q.val != b_q.val};
				dcp_pkg::K_LT:  quick_nv.val = {63'd0, lt_ab};
				dcp_pkg::K_GT:  quick_nv.val = {63'd0, lt_ba};
				dcp_pkg::K_LE:  quick_nv.val = {63'd0, !lt_ba};
				dcp_pkg::K_GE:  quick_nv.val = {63'd0, !lt_ab};
				default:        quick_nv = '{kind: dcp_pkg::LAT_OVER, val: 64'd0};
			endcase
		end
	end

	// one step of shift-add multiply on raw values or restoring divide on magnitudes
	logic [63:0] q_fin, r_fin;

	assign trial = {acc_q[62:0], x_q[63]};
	always_comb begin
		if (nd_q.kind == dcp_pkg::K_MUL) begin
			acc_nx = y_q[0] ? acc_q + x_q : acc_q;
			x_nx   = {x_q[62:0], 1'b0};
			y_nx   = {1'b0, y_q[63:1]};
		end else begin
			y_nx = y_q;
			if (trial >= y_q) begin
				acc_nx = trial - y_q;
				x_nx   = {x_q[62:0], 1'b1};
			end else begin
				acc_nx = trial;
				x_nx   = {x_q[62:0], 1'b0};
			end
		end
	end
	assign q_fin = (a_q.val[63] ^ b_q.val[63]) ? 64'd0 - x_nx : x_nx;
	assign r_fin = a_q.val[63] ? 64'd0 - acc_nx : acc_nx;

	// next state and memory strobes
	always_comb begin
		state_d     = state_q;
		node_re     = 1'b0;
		node_raddr  = idx_q;
		lat_re_a    = 1'b0;
		lat_re_b    = 1'b0;
		lat_raddr_a = idx_q;
		lat_raddr_b = idx_q;
		lat_we      = 1'b0;
		unique case (state_q)
			dcp_pkg::S_LOAD: begin
				if (s_acc && s_tlast) state_d = dcp_pkg::S_RD_NODE;
			end
			dcp_pkg::S_RD_NODE: begin
				node_re = 1'b1;
				state_d = dcp_pkg::S_OPS;
			end
			dcp_pkg::S_OPS: begin
				if (node_rd.dead) begin
					if (!last_i) state_d = dcp_pkg::S_RD_NODE;
					else state_d = more_sweeps ? dcp_pkg::S_RD_NODE : dcp_pkg::S_OUT_RD;
				end else begin
					state_d = dcp_pkg::S_OWN;
				end
			end
			dcp_pkg::S_OWN: begin
				lat_re_a = 1'b1;
				state_d  = dcp_pkg::S_EVAL;
			end
			dcp_pkg::S_EVAL: begin
				state_d = need_iter ? dcp_pkg::S_ITER : dcp_pkg::S_WB;
			end
			dcp_pkg::S_ITER: begin
				if (cnt_q == dcp_pkg::ITER_LAST) state_d = dcp_pkg::S_WB;
			end
			dcp_pkg::S_WB: begin
				lat_we = chg;
				if (!last_i) state_d = dcp_pkg::S_RD_NODE;
				else state_d = more_sweeps ? dcp_pkg::S_RD_NODE : dcp_pkg::S_OUT_RD;
			end
			dcp_pkg::S_OUT_RD: begin
				node_re  = 1'b1;
				lat_re_a = 1'b1;
				state_d  = dcp_pkg::S_OUT_CAP;
			end
			dcp_pkg::S_OUT_CAP: begin
				if (m_free) state_d = last_i ? dcp_pkg::S_LOAD : dcp_pkg::S_OUT_RD;
			end
			default: state_d = dcp_pkg::S_LOAD;
		endcase
		// operand reads are issued as the node word arrives
		if (state_q == dcp_pkg::S_OPS) begin
			lat_re_a    = 1'b1;
			lat_re_b    = 1'b1;
			lat_raddr_a = AW'(node_rd.left - 7'd1);
			lat_raddr_b = AW'(node_rd.right - 7'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dcp_pkg::S_LOAD;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			sweep_q    <= '0;
			changed_q  <= 1'b0;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// load a new word or drop the one taken
			if (state_q == dcp_pkg::S_OUT_CAP && m_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q) inside
				dcp_pkg::S_LOAD: begin
					if (node_we) count_q <= count_q + CW'(1);
					if (s_acc && s_tlast) begin
						// start a run: everything unknown, first sweep
						idx_q     <= '0;
						sweep_q   <= '0;
						changed_q <= 1'b0;
						vld_q     <= '0;
					end
				end
				dcp_pkg::S_OPS, dcp_pkg::S_WB: begin
					if (state_q == dcp_pkg::S_WB || node_rd.dead) begin
						if (chg) vld_q[idx_q] <= 1'b1;
						if (!last_i) begin
							idx_q <= idx_q + AW'(1);
							if (chg) changed_q <= 1'b1;
						end else begin
							// wrap: either sweep again or report
							idx_q <= '0;
							if (more_sweeps) begin
								sweep_q   <= sweep_q + SW'(1);
								changed_q <= 1'b0;
							end
						end
					end
				end
				dcp_pkg::S_OUT_CAP: begin
					if (m_free) begin
						if (last_i) begin
							count_q <= '0;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			dcp_pkg::S_OPS: begin
				nd_q    <= node_rd;
				a_vld_q <= (node_rd.left != 7'd0) &&
					({1'b0, node_rd.left} <= 8'(count_q)) &&
					vld_q[AW'(node_rd.left - 7'd1)];
				b_vld_q <= (node_rd.right != 7'd0) &&
					({1'b0, node_rd.right} <= 8'(count_q)) &&
					vld_q[AW'(node_rd.right - 7'd1)];
			end
			dcp_pkg::S_OWN: begin
				a_q       <= a_vld_q ? lat_a_rd : '0;
				b_q       <= b_vld_q ? lat_b_rd : '0;
				own_vld_q <= vld_q[idx_q];
			end
			dcp_pkg::S_EVAL: begin
				nv_q  <= quick_nv;
				cnt_q <= '0;
				acc_q <= '0;
				if (nd_q.kind == dcp_pkg::K_MUL) begin
					x_q <= a_q.val;
					y_q <= b_q.val;
				end else begin
					x_q <= a_q.val[63] ? 64'd0 - a_q.val : a_q.val;
					y_q <= b_q.val[63] ? 64'd0 - b_q.val : b_q.val;
				end
			end
			dcp_pkg::S_ITER: begin
				acc_q <= acc_nx;
				x_q   <= x_nx;
				y_q   <= y_nx;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == dcp_pkg::ITER_LAST) begin
					case (nd_q.kind)
						dcp_pkg::K_MUL: nv_q <= '{kind: dcp_pkg::LAT_CONST, val: acc_nx};
						dcp_pkg::K_DIV: nv_q <= '{kind: dcp_pkg::LAT_CONST, val: q_fin};
						default:        nv_q <= '{kind: dcp_pkg::LAT_CONST, val: r_fin};
					endcase
				end
			end
			dcp_pkg::S_OUT_RD: begin
				own_vld_q <= vld_q[idx_q];
			end
			dcp_pkg::S_OUT_CAP: begin
				if (m_free) begin
					m_tuser_q <= old_val.kind;
					m_tlast_q <= last_i;
					m_tdata_q <= {
						!node_rd.dead && node_rd.is_pure && !node_rd.already_const &&
							(old_val.kind == dcp_pkg::LAT_CONST),
						(old_val.kind == dcp_pkg::LAT_CONST) ? old_val.val : 64'd0,
						7'(idx_q) + 7'd1
					};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
